>>> rtl/core/lfcc_pkg.sv
package lfcc_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       char_present;
        logic       field_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  field_type;
        logic [15:0] field_checksum;
    } t_out_item;

    typedef struct packed {
        logic [8:0]  class_bits;
        logic [1:0]  dot_count;
        logic        letter_after_dot;
        logic        forced_other;
        logic        first_is_slash;
        logic        at_field_start;
        logic [15:0] running_crc;
    } t_field_state;

    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

    localparam logic [8:0] CB_EMAIL = 9'h001;
    localparam logic [8:0] CB_PATH  = 9'h002;
    localparam logic [8:0] CB_DOT   = 9'h004;
    localparam logic [8:0] CB_DASH  = 9'h008;
    localparam logic [8:0] CB_DIGIT = 9'h010;
    localparam logic [8:0] CB_OTHER = 9'h020;
    localparam logic [8:0] CB_HEX   = 9'h040;
    localparam logic [8:0] CB_ALPHA = 9'h080;
    localparam logic [8:0] CB_USC   = 9'h100;

    localparam logic [8:0] MASK_IP    = CB_PATH | CB_EMAIL | CB_USC | CB_OTHER | CB_ALPHA | CB_HEX;
    localparam logic [8:0] MASK_NUM   = CB_PATH | CB_EMAIL | CB_USC | CB_OTHER | CB_ALPHA;
    localparam logic [8:0] MASK_FQDN  = CB_PATH | CB_EMAIL | CB_USC | CB_OTHER;
    localparam logic [8:0] MASK_EMAIL = CB_PATH;

    localparam logic [2:0] TYPE_IP     = 3'd0;
    localparam logic [2:0] TYPE_NUMBER = 3'd1;
    localparam logic [2:0] TYPE_DOMAIN = 3'd2;
    localparam logic [2:0] TYPE_PATH   = 3'd3;
    localparam logic [2:0] TYPE_EMAIL  = 3'd4;
    localparam logic [2:0] TYPE_OTHER  = 3'd5;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [1:0]  DOT_MAX  = 2'd3;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_USC   = 8'h5F;

    localparam t_field_state FIELD_INIT = '{
        class_bits:       9'h000,
        dot_count:        2'd0,
        letter_after_dot: 1'b0,
        forced_other:     1'b0,
        first_is_slash:   1'b0,
        at_field_start:   1'b1,
        running_crc:      16'h0000
    };

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_field_state class_update(input t_field_state s, input logic [7:0] c);
        t_field_state r;
        logic         is_lower;
        logic         is_upper;
        r        = s;
        is_lower = (c >= 8'h61) && (c <= 8'h7A);
        is_upper = (c >= 8'h41) && (c <= 8'h5A);
        if (c[7]) begin
            r.forced_other = 1'b1;
        end else if ((c >= 8'h30) && (c <= 8'h39)) begin
            r.class_bits = s.class_bits | CB_DIGIT;
        end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
            r.class_bits = s.class_bits | CB_HEX;
        end else if (c == CHAR_DOT) begin
            r.class_bits = s.class_bits | CB_DOT;
            if (s.dot_count != DOT_MAX) begin
                r.dot_count = s.dot_count + 2'd1;
            end
        end else if (c == CHAR_SLASH) begin
            r.class_bits = s.class_bits | CB_PATH;
        end else if (c == CHAR_AT) begin
            r.class_bits = s.class_bits | CB_EMAIL;
        end else if (c == CHAR_DASH) begin
            r.class_bits = s.class_bits | CB_DASH;
        end else if (c == CHAR_USC) begin
            r.class_bits = s.class_bits | CB_USC;
        end else if (is_lower || is_upper) begin
            if ((s.class_bits & CB_DOT) != 9'h000) begin
                r.letter_after_dot = 1'b1;
            end
            r.class_bits = s.class_bits | CB_ALPHA;
        end else begin
            r.class_bits = s.class_bits | CB_OTHER;
        end
        return r;
    endfunction

    function automatic logic [2:0] field_code(input t_field_state s);
        logic [8:0] f;
        logic [2:0] code;
        f = s.class_bits;
        if (s.forced_other) begin
            code = TYPE_OTHER;
        end else if (((f & MASK_IP) == 9'h000) && ((f & CB_DOT) != 9'h000)
                     && ((f & CB_DIGIT) != 9'h000) && (s.dot_count == DOT_MAX)) begin
            code = TYPE_IP;
        end else if (((f & MASK_NUM) == 9'h000) && ((f & (CB_DIGIT | CB_HEX)) != 9'h000)) begin
            code = TYPE_NUMBER;
        end else if (((f & MASK_FQDN) == 9'h000) && ((f & CB_DOT) != 9'h000)
                     && ((f & CB_ALPHA) != 9'h000) && s.letter_after_dot) begin
            code = TYPE_DOMAIN;
        end else if (s.first_is_slash) begin
            code = TYPE_PATH;
        end else if (((f & MASK_EMAIL) == 9'h000) && ((f & CB_EMAIL) != 9'h000)
                     && ((f & CB_ALPHA) != 9'h000)) begin
            code = TYPE_EMAIL;
        end else begin
            code = TYPE_OTHER;
        end
        return code;
    endfunction

endpackage

>>> rtl/core/lfcc_in_stage.sv
module lfcc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_advance,
    input  lfcc_pkg::t_in_item i_item,
    output logic              o_valid,
    output lfcc_pkg::t_in_item o_item
);

    logic               r_valid;
    lfcc_pkg::t_in_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/lfcc_field_unit.sv
module lfcc_field_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lfcc_pkg::t_stage_ctl i_ctl,
    input  lfcc_pkg::t_in_item   i_item,
    output lfcc_pkg::t_out_item  o_result
);

    lfcc_pkg::t_field_state r_state;
    lfcc_pkg::t_field_state n_state;
    lfcc_pkg::t_field_state w_seen;

    always_comb begin
        w_seen = r_state;
        if (i_item.char_present) begin
            if (r_state.at_field_start && (i_item.char_byte == lfcc_pkg::CHAR_SLASH)) begin
                w_seen.first_is_slash = 1'b1;
            end
            w_seen.at_field_start = 1'b0;
            w_seen.running_crc    = lfcc_pkg::crc_update(r_state.running_crc, i_item.char_byte);
            if (!r_state.forced_other) begin
                w_seen = lfcc_pkg::class_update(w_seen, i_item.char_byte);
            end
        end
        n_state = i_item.field_end ? lfcc_pkg::FIELD_INIT : w_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfcc_pkg::FIELD_INIT;
        end else if (i_ctl.advance) begin
            r_state <= n_state;
        end
    end

    assign o_result.field_type     = lfcc_pkg::field_code(w_seen);
    assign o_result.field_checksum = w_seen.running_crc;

    a_field_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.advance && i_item.field_end)
        |=> (r_state.at_field_start && (r_state.running_crc == 16'h0000)))
        else $error("Field state was not cleared after the end of a field.");

    a_forced_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seen.forced_other |-> (o_result.field_type == lfcc_pkg::TYPE_OTHER))
        else $error("A field with a high byte was not typed as other.");

    a_advance_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.advance |-> i_ctl.valid)
        else $error("Field state advanced with no transaction in the input register.");

endmodule

>>> rtl/core/lfcc_out_stage.sv
module lfcc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lfcc_pkg::t_out_item  i_result,
    input  logic                i_stall,
    output logic                o_free,
    output logic                o_valid,
    output lfcc_pkg::t_out_item  o_item
);

    logic                r_valid;
    lfcc_pkg::t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/log_field_classifier_crc_unit.sv
// Classifies each field of a log message and computes its CRC-16/ARC checksum. Characters
// enter one per transaction with field_end set on the last one; a transaction without a
// character but with field_end set closes the field as it stands, and alone gives an empty
// field of type other with checksum zero. Each field yields one result transaction with a
// type code and the checksum, presented once the closing transaction leaves the input
// register. The block accepts one transaction every cycle unless the input stalls: the
// per-field state, the byte-wide CRC step and the class update form combinational logic
// between the input and field state registers. An output register holds the result, so
// character transactions keep flowing while a result waits; a closing transaction waits
// in the input register, and stalls the input, until the output register is free.
module log_field_classifier_crc_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lfcc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output lfcc_pkg::t_out_item o_item
);

    logic                 w_in_valid;
    lfcc_pkg::t_in_item   w_in_item;
    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_out_load;
    logic                 w_in_load;
    lfcc_pkg::t_stage_ctl w_ctl;
    lfcc_pkg::t_out_item  w_result;

    assign w_advance  = w_in_valid && (!w_in_item.field_end || w_out_free);
    assign w_out_load = w_advance && w_in_item.field_end;
    assign o_stall    = w_in_valid && !w_advance;
    assign w_in_load  = i_valid && !o_stall;

    assign w_ctl.valid   = w_in_valid;
    assign w_ctl.advance = w_advance;

    lfcc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_in_load),
        .i_advance (w_advance),
        .i_item    (i_item),
        .o_valid   (w_in_valid),
        .o_item    (w_in_item)
    );

    lfcc_field_unit u_field_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_item   (w_in_item),
        .o_result (w_result)
    );

    lfcc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_out_load),
        .i_result (w_result),
        .i_stall  (i_stall),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .o_item   (o_item)
    );

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_in_valid && w_in_item.field_end && o_valid && i_stall))
        else $error("Input stalled without a pending field end blocked by the output.");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_valid)
        else $error("A field result was loaded but not presented.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !w_out_load)
        else $error("A stalled result transaction was overwritten.");

endmodule
